>>> hdl/tcc_pkg.sv
// -----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the text console cursor controller
// Holds the command codes, register indexes, character codes and the structs
// that travel between the sequencer, the step logic and the result register.
// -----------------------------------------------------------------------------
package tcc_pkg;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int ATTR_W  = 5;
   localparam int GLYPH_W = 7;
   localparam int CHAR_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // Screen size used to saturate the cursor when it steps past the edge.
   localparam int SCREEN_ROWS = 25;
   localparam int SCREEN_COLS = 80;

   // At most this many write, scroll or beep results per item; the cursor result
   // that closes the item is always sent on top of these.
   localparam int MAX_NONLAST = 11;
   localparam int CNT_W       = 4;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_CURSOR = 2'd2,
      CMD_BEEP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEXT_ATTRIBUTE = 3'd0,
      REG_WINDOW_TOP     = 3'd1,
      REG_WINDOW_BOTTOM  = 3'd2,
      REG_WINDOW_LEFT    = 3'd3,
      REG_WINDOW_RIGHT   = 3'd4
   } reg_index_type;

   localparam logic [CHAR_W-1:0] CH_BELL  = 8'd7;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   typedef struct packed {
      logic [ATTR_W-1:0] text_attribute;
      logic [ROW_W-1:0]  window_top;
      logic [ROW_W-1:0]  window_bottom;
      logic [COL_W-1:0]  window_left;
      logic [COL_W-1:0]  window_right;
   } cfg_type;

   typedef struct packed {
      cmd_type            command;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [GLYPH_W-1:0] glyph;
      logic [ATTR_W-1:0]  attribute;
      logic               last;
   } rsp_type;

endpackage

>>> hdl/tcc_step.sv
// -----------------------------------------------------------------------------
// tcc_step: one step of character handling
// Given the held character and the progress flags, produces one result and the
// cursor and progress values that follow it.
// -----------------------------------------------------------------------------
module tcc_step #(
   parameter int TAB_WIDTH = 8,
   parameter int TAB_CNT_W = 4
) (
   input  logic [tcc_pkg::CHAR_W-1:0] char_code,
   input  tcc_pkg::cfg_type           cfg,
   input  logic [tcc_pkg::ROW_W-1:0]  cur_row,
   input  logic [tcc_pkg::COL_W-1:0]  cur_col,
   input  logic                       scroll_pend,
   input  logic                       main_done,
   input  logic [TAB_CNT_W-1:0]       tab_cnt,
   input  logic [tcc_pkg::CNT_W-1:0]  emit_cnt,
   output tcc_pkg::rsp_type           rsp,
   output logic                       rsp_emit,
   output logic                       final_step,
   output logic [tcc_pkg::ROW_W-1:0]  row_nx,
   output logic [tcc_pkg::COL_W-1:0]  col_nx,
   output logic                       scroll_pend_nx,
   output logic                       main_done_nx,
   output logic [TAB_CNT_W-1:0]       tab_cnt_nx,
   output logic [tcc_pkg::CNT_W-1:0]  emit_cnt_nx
);
   import tcc_pkg::*;

   logic is_print;
   logic at_right;
   logic at_bottom;
   logic [ROW_W-1:0] row_up;
   logic [COL_W-1:0] col_up;
   logic [ROW_W-1:0] adv_row;
   logic [COL_W-1:0] adv_col;
   logic             adv_pend;
   logic             room;

   // Increments saturate at the last screen row or column.
   assign row_up = (32'(cur_row) >= SCREEN_ROWS - 1) ? ROW_W'(SCREEN_ROWS - 1)
                                                     : cur_row + ROW_W'(1);
   assign col_up = (32'(cur_col) >= SCREEN_COLS - 1) ? COL_W'(SCREEN_COLS - 1)
                                                     : cur_col + COL_W'(1);

   assign is_print  = (char_code[7] == 1'b0) && (char_code >= CH_SPACE);
   assign at_right  = (cur_col == cfg.window_right);
   assign at_bottom = (cur_row == cfg.window_bottom);
   assign room      = (emit_cnt < CNT_W'(MAX_NONLAST));

   // Cursor advance after a written character.
   always_comb begin
      adv_row  = cur_row;
      adv_col  = col_up;
      adv_pend = 1'b0;
      if (at_right) begin
         adv_col = cfg.window_left;
         if (at_bottom) begin
            adv_pend = 1'b1;
         end else begin
            adv_row = row_up;
         end
      end
   end

   always_comb begin
      row_nx         = cur_row;
      col_nx         = cur_col;
      scroll_pend_nx = 1'b0;
      main_done_nx   = main_done;
      tab_cnt_nx     = tab_cnt;
      final_step     = 1'b0;
      rsp            = '0;
      rsp.command    = CMD_CURSOR;

      priority if (scroll_pend) begin
         rsp.command = CMD_SCROLL;
      end else if (!main_done && is_print) begin
         rsp.command    = CMD_WRITE;
         rsp.row        = cur_row;
         rsp.col        = cur_col;
         rsp.glyph      = char_code[GLYPH_W-1:0];
         rsp.attribute  = cfg.text_attribute;
         row_nx         = adv_row;
         col_nx         = adv_col;
         scroll_pend_nx = adv_pend;
         main_done_nx   = 1'b1;
      end else if (!main_done && (char_code == CH_TAB)) begin
         rsp.command    = CMD_WRITE;
         rsp.row        = cur_row;
         rsp.col        = cur_col;
         rsp.glyph      = CH_SPACE[GLYPH_W-1:0];
         rsp.attribute  = cfg.text_attribute;
         row_nx         = adv_row;
         col_nx         = adv_col;
         scroll_pend_nx = adv_pend;
         tab_cnt_nx     = tab_cnt + TAB_CNT_W'(1);
         main_done_nx   = (tab_cnt == TAB_CNT_W'(TAB_WIDTH - 1));
      end else if (!main_done && (char_code == CH_BELL)) begin
         rsp.command  = CMD_BEEP;
         main_done_nx = 1'b1;
      end else if (!main_done && (char_code == CH_LF) && at_bottom) begin
         rsp.command  = CMD_SCROLL;
         main_done_nx = 1'b1;
      end else if (!main_done && (char_code == CH_BS)
                   && !((cur_col == cfg.window_left) && (cur_row == cfg.window_top))) begin
         // Erase the previous cell, stepping back to the row above at the left edge.
         if (cur_col == cfg.window_left) begin
            row_nx = cur_row - ROW_W'(1);
            col_nx = cfg.window_right;
         end else begin
            col_nx = cur_col - COL_W'(1);
         end
         rsp.command   = CMD_WRITE;
         rsp.row       = row_nx;
         rsp.col       = col_nx;
         rsp.glyph     = CH_SPACE[GLYPH_W-1:0];
         rsp.attribute = cfg.text_attribute;
         main_done_nx  = 1'b1;
      end else begin
         // Closing cursor report; line feed and carriage return move first.
         if (!main_done && (char_code == CH_LF)) begin
            row_nx = row_up;
         end else if (!main_done && (char_code == CH_CR)) begin
            col_nx = cfg.window_left;
         end
         final_step   = 1'b1;
         main_done_nx = 1'b1;
         rsp.command  = CMD_CURSOR;
         rsp.row      = row_nx;
         rsp.col      = col_nx;
         rsp.last     = 1'b1;
      end
   end

   assign rsp_emit    = final_step || room;
   assign emit_cnt_nx = (!final_step && room) ? emit_cnt + CNT_W'(1) : emit_cnt;

endmodule

>>> hdl/tcc_out_reg.sv
// -----------------------------------------------------------------------------
// tcc_out_reg: result register
// Holds one result until the consumer takes it and tells the sequencer when a
// new result may be loaded.
// -----------------------------------------------------------------------------
module tcc_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  tcc_pkg::rsp_type data_in,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output tcc_pkg::rsp_type data_out,
   output logic             free
);
   import tcc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> hdl/text_console_cursor_controller.sv
// Once an item is held, its first result is loaded into the result register as soon as that register is free,
// and the item then takes one step per cycle while the consumer keeps taking the results.
// An item has 1 to 17 steps (a tab in a one-column
// window at the bottom row has eight writes, eight scrolls and the cursor report).
// The step sequencer and the single result register set this pace.
// Reset is synchronous and active high; it restores the window registers and homes the cursor.
// -----------------------------------------------------------------------------
// text_console_cursor_controller: teletype style cursor control for a text window
// Turns character codes into write, scroll, beep and cursor commands for a display.
// -----------------------------------------------------------------------------
module text_console_cursor_controller #(
   parameter int TAB_WIDTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcc_pkg::CHAR_W-1:0]          req_char_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_command,
   output logic [tcc_pkg::ROW_W-1:0]           rsp_row,
   output logic [tcc_pkg::COL_W-1:0]           rsp_col,
   output logic [tcc_pkg::GLYPH_W-1:0]         rsp_glyph,
   output logic [tcc_pkg::ATTR_W-1:0]          rsp_attribute,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [tcc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tcc_pkg::*;

   // The tab counter has to hold every count up to the tab width.
   localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

   // Window and attribute registers, to be written only while the block is idle; the block does not enforce this.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // The sequencer holds the current item and how far its handling has come.
   logic                 busy_ff,  busy_in;
   logic [CHAR_W-1:0]    char_ff;
   logic [ROW_W-1:0]     row_ff,   row_in;
   logic [COL_W-1:0]     col_ff,   col_in;
   logic                 pend_ff,  pend_in;
   logic                 done_ff,  done_in;
   logic [TAB_CNT_W-1:0] tab_ff,   tab_in;
   logic [CNT_W-1:0]     cnt_ff,   cnt_in;

   rsp_type              step_rsp;
   logic                 step_emit;
   logic                 step_final;
   logic [ROW_W-1:0]     step_row;
   logic [COL_W-1:0]     step_col;
   logic                 step_pend;
   logic                 step_done;
   logic [TAB_CNT_W-1:0] step_tab;
   logic [CNT_W-1:0]     step_cnt;

   logic    out_free;
   logic    advance;
   logic    accept;
   rsp_type out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TEXT_ATTRIBUTE: cfg_in.text_attribute = csr_wdata[ATTR_W-1:0];
            REG_WINDOW_TOP:     cfg_in.window_top     = csr_wdata[ROW_W-1:0];
            REG_WINDOW_BOTTOM:  cfg_in.window_bottom  = csr_wdata[ROW_W-1:0];
            REG_WINDOW_LEFT:    cfg_in.window_left    = csr_wdata[COL_W-1:0];
            REG_WINDOW_RIGHT:   cfg_in.window_right   = csr_wdata[COL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_attribute <= '0;
         cfg_ff.window_top     <= '0;
         cfg_ff.window_bottom  <= ROW_W'(23);
         cfg_ff.window_left    <= '0;
         cfg_ff.window_right   <= COL_W'(79);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcc_step #(
      .TAB_WIDTH (TAB_WIDTH),
      .TAB_CNT_W (TAB_CNT_W)
   ) u_step (
      .char_code      (char_ff),
      .cfg            (cfg_ff),
      .cur_row        (row_ff),
      .cur_col        (col_ff),
      .scroll_pend    (pend_ff),
      .main_done      (done_ff),
      .tab_cnt        (tab_ff),
      .emit_cnt       (cnt_ff),
      .rsp            (step_rsp),
      .rsp_emit       (step_emit),
      .final_step     (step_final),
      .row_nx         (step_row),
      .col_nx         (step_col),
      .scroll_pend_nx (step_pend),
      .main_done_nx   (step_done),
      .tab_cnt_nx     (step_tab),
      .emit_cnt_nx    (step_cnt)
   );

   // A step is taken whenever the result register can take what it produces.
   // Steps whose result is dropped by the per-item limit still move the cursor.
   assign advance = busy_ff && out_free;

   // A new item is taken while idle or in the cycle that the current one closes,
   // so single-result items follow each other without a gap.
   assign req_ready = !busy_ff || (advance && step_final);
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      pend_in = pend_ff;
      done_in = done_ff;
      tab_in  = tab_ff;
      cnt_in  = cnt_ff;
      if (advance) begin
         row_in  = step_row;
         col_in  = step_col;
         pend_in = step_pend;
         done_in = step_done;
         tab_in  = step_tab;
         cnt_in  = step_cnt;
         if (step_final) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = 1'b1;
         pend_in = 1'b0;
         done_in = 1'b0;
         tab_in  = '0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
         col_ff  <= '0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
         tab_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
         tab_ff  <= tab_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_code;
      end
   end

   tcc_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && step_emit),
      .data_in   (step_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .data_out  (out_data),
      .free      (out_free)
   );

   assign rsp_command   = out_data.command;
   assign rsp_row       = out_data.row;
   assign rsp_col       = out_data.col;
   assign rsp_glyph     = out_data.glyph;
   assign rsp_attribute = out_data.attribute;
   assign rsp_last      = out_data.last;

endmodule

>>> hdl/tcc_checker.sv
// -----------------------------------------------------------------------------
// tcc_checker: port checks for the text console cursor controller
// Watches the result channel and flags results that break the command format.
// -----------------------------------------------------------------------------
module tcc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_command,
   input logic [tcc_pkg::ROW_W-1:0]     rsp_row,
   input logic [tcc_pkg::COL_W-1:0]     rsp_col,
   input logic [tcc_pkg::GLYPH_W-1:0]   rsp_glyph,
   input logic [tcc_pkg::ATTR_W-1:0]    rsp_attribute,
   input logic                          rsp_last
);
   import tcc_pkg::*;

   // A result held back by the consumer stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command) && $stable(rsp_row)
         && $stable(rsp_col) && $stable(rsp_last))
   else $error("result changed while stalled");

   // Only the closing cursor report carries the last flag, and it always does.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_command == CMD_CURSOR)))
   else $error("last flag does not match cursor command");

   // Scroll and beep carry no position or character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == CMD_SCROLL || rsp_command == CMD_BEEP)
         |-> rsp_row == '0 && rsp_col == '0 && rsp_glyph == '0 && rsp_attribute == '0)
   else $error("scroll or beep carries payload");

   // Cursor reports carry no character or attribute.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == CMD_CURSOR |-> rsp_glyph == '0 && rsp_attribute == '0)
   else $error("cursor report carries character data");

endmodule

bind text_console_cursor_controller tcc_checker u_tcc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_command   (rsp_command),
   .rsp_row       (rsp_row),
   .rsp_col       (rsp_col),
   .rsp_glyph     (rsp_glyph),
   .rsp_attribute (rsp_attribute),
   .rsp_last      (rsp_last)
);
